// ===== rtl/fcr_pkg.sv =====
`timescale 1ns / 1ps
package fcr_pkg;

	localparam int BYTE_W          = 8;
	localparam int CFG_ADDR_W      = 5;
	localparam int CFG_DATA_W      = 32;
	localparam int FRAME_OVERHEAD  = 5;
	localparam int REPLY_OVERHEAD  = 4;
	localparam int CK_OFFSET       = 3;
	localparam logic [BYTE_W-1:0] SEED_RESET = 8'h10;
	localparam int QUEUE_DEPTH     = 4;

	localparam int RX_BUFFER_BYTES_DEF = 64;
	localparam int TX_BUFFER_BYTES_DEF = 32;
	localparam int CHECK_RX_SUM_DEF    = 1;

	typedef enum logic [1:0] {
		VERD_OK_NONE = 2'd0,
		VERD_REPLY   = 2'd1,
		VERD_INVALID = 2'd2,
		VERD_LEN_ERR = 2'd3
	} verd_t;

	typedef enum logic {
		KIND_VERDICT = 1'b0,
		KIND_BYTE    = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		REG_HEADER    = 3'd0,
		REG_TAIL      = 3'd1,
		REG_SHORT_CMD = 3'd2,
		REG_LONG_CMD  = 3'd3,
		REG_SHORT_REG = 3'd4,
		REG_LONG_REG  = 3'd5,
		REG_SHORT_LEN = 3'd6,
		REG_LONG_LEN  = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		GS_IDLE,
		GS_REG,
		GS_LEN,
		GS_DATA,
		GS_SUM,
		GS_TAIL
	} gen_state_t;

	typedef struct packed {
		logic [BYTE_W-1:0] header_byte;
		logic [BYTE_W-1:0] tail_byte;
		logic [BYTE_W-1:0] short_read_cmd;
		logic [BYTE_W-1:0] long_read_cmd;
		logic [BYTE_W-1:0] short_reply_reg;
		logic [BYTE_W-1:0] long_reply_reg;
		logic [BYTE_W-1:0] short_reply_len;
		logic [BYTE_W-1:0] long_reply_len;
	} cfg_t;

	// one finished frame, handed from the checker to the reply generator
	typedef struct packed {
		verd_t             verd;
		logic [BYTE_W-1:0] reg_b;
		logic [BYTE_W-1:0] dlen;
	} job_t;

endpackage

// ===== rtl/fcr_in_if.sv =====
`timescale 1ns / 1ps
interface fcr_in_if;
	logic       valid;
	logic       ready;
	logic       has_byte;
	logic [7:0] rx_byte;
	logic       frame_end;

	modport source(output valid, output has_byte, output rx_byte, output frame_end,
		input ready);
	modport sink(input valid, input has_byte, input rx_byte, input frame_end,
		output ready);
endinterface

// ===== rtl/fcr_out_if.sv =====
`timescale 1ns / 1ps
interface fcr_out_if;
	logic       valid;
	logic       ready;
	logic       item_kind;
	logic [1:0] verdict;
	logic [7:0] reply_byte;
	logic       last_of_run;

	modport source(output valid, output item_kind, output verdict, output reply_byte,
		output last_of_run, input ready);
	modport sink(input valid, input item_kind, input verdict, input reply_byte,
		input last_of_run, output ready);
endinterface

// ===== rtl/fcr_front.sv =====
`timescale 1ns / 1ps
module fcr_front #(
	parameter int RX_BUFFER_BYTES = fcr_pkg::RX_BUFFER_BYTES_DEF,
	parameter int TX_BUFFER_BYTES = fcr_pkg::TX_BUFFER_BYTES_DEF,
	parameter int CHECK_RX_SUM    = fcr_pkg::CHECK_RX_SUM_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	fcr_in_if.sink        req,
	input  fcr_pkg::cfg_t cfg,
	input  logic          q_full,
	output logic          q_push,
	output fcr_pkg::job_t q_job
);

	localparam int W  = fcr_pkg::BYTE_W;
	localparam logic [W:0] RX_LIM = (W+1)'(RX_BUFFER_BYTES);
	localparam logic [W:0] TX_LIM = (W+1)'(TX_BUFFER_BYTES);

	logic [W-1:0] byte_count_q, cmd_q, plen_q, rsum_q, prev_q;
	logic         header_ok_q, sum_ok_q, ovf_q;

	logic [W-1:0] byte_count_n, cmd_n, plen_n, rsum_n, prev_n;
	logic         header_ok_n, sum_ok_n, ovf_n;

	logic [W:0]   idx_x, ck_x;
	logic         accept, valid_frame, short_hit, long_hit, len_bad;
	logic [W-1:0] sel_reg, sel_len;

	assign req.ready = !q_full;
	assign accept    = req.valid && req.ready;

	assign idx_x = {1'b0, byte_count_q};
	assign ck_x  = {1'b0, plen_q} + (W+1)'(fcr_pkg::CK_OFFSET);

	// state after this word's byte, before any frame-end clear
	always_comb begin
		byte_count_n = byte_count_q;
		cmd_n        = cmd_q;
		plen_n       = plen_q;
		rsum_n       = rsum_q;
		prev_n       = prev_q;
		header_ok_n  = header_ok_q;
		sum_ok_n     = sum_ok_q;
		ovf_n        = ovf_q;
		if (req.has_byte) begin
			if (idx_x >= RX_LIM) begin
				ovf_n = 1'b1;
			end else begin
				if (idx_x == (W+1)'(0)) begin
					header_ok_n = (req.rx_byte == cfg.header_byte);
				end else if (idx_x == (W+1)'(1)) begin
					cmd_n  = req.rx_byte;
					rsum_n = rsum_q + req.rx_byte;
				end else if (idx_x == (W+1)'(2)) begin
					plen_n = req.rx_byte;
					rsum_n = rsum_q + req.rx_byte;
				end else if (idx_x < ck_x) begin
					rsum_n = rsum_q + req.rx_byte;
				end else if (idx_x == ck_x) begin
					sum_ok_n = (req.rx_byte == rsum_q);
				end
				prev_n       = req.rx_byte;
				byte_count_n = byte_count_q + W'(1);
			end
		end
	end

	always_comb begin
		valid_frame = !ovf_n && ({1'b0, byte_count_n} >= (W+1)'(fcr_pkg::FRAME_OVERHEAD))
			&& header_ok_n && (prev_n == cfg.tail_byte)
			&& ({1'b0, byte_count_n} == {1'b0, plen_n} + (W+1)'(fcr_pkg::FRAME_OVERHEAD))
			&& ((CHECK_RX_SUM == 0) || sum_ok_n);
		short_hit = (cmd_n == cfg.short_read_cmd);
		long_hit  = (cmd_n == cfg.long_read_cmd);
		sel_reg   = short_hit ? cfg.short_reply_reg : cfg.long_reply_reg;
		sel_len   = short_hit ? cfg.short_reply_len : cfg.long_reply_len;
		len_bad   = (sel_len == W'(0))
			|| ({1'b0, sel_len} + (W+1)'(fcr_pkg::REPLY_OVERHEAD) > TX_LIM);

		q_job.reg_b = sel_reg;
		q_job.dlen  = sel_len;
		priority if (!valid_frame)
			q_job.verd = fcr_pkg::VERD_INVALID;
		else if (!(short_hit || long_hit))
			q_job.verd = fcr_pkg::VERD_OK_NONE;
		else if (len_bad)
			q_job.verd = fcr_pkg::VERD_LEN_ERR;
		else
			q_job.verd = fcr_pkg::VERD_REPLY;
	end

	assign q_push = accept && req.frame_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			cmd_q        <= '0;
			plen_q       <= '0;
			rsum_q       <= '0;
			prev_q       <= '0;
			header_ok_q  <= 1'b0;
			sum_ok_q     <= 1'b0;
			ovf_q        <= 1'b0;
		end else if (accept) begin
			if (req.frame_end) begin
				byte_count_q <= '0;
				cmd_q        <= '0;
				plen_q       <= '0;
				rsum_q       <= '0;
				prev_q       <= '0;
				header_ok_q  <= 1'b0;
				sum_ok_q     <= 1'b0;
				ovf_q        <= 1'b0;
			end else begin
				byte_count_q <= byte_count_n;
				cmd_q        <= cmd_n;
				plen_q       <= plen_n;
				rsum_q       <= rsum_n;
				prev_q       <= prev_n;
				header_ok_q  <= header_ok_n;
				sum_ok_q     <= sum_ok_n;
				ovf_q        <= ovf_n;
			end
		end
	end

endmodule

// ===== rtl/fcr_queue.sv =====
`timescale 1ns / 1ps
module fcr_queue #(
	parameter int DEPTH = fcr_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  fcr_pkg::job_t job_in,
	input  logic          pop,
	output fcr_pkg::job_t job_out,
	output logic          full,
	output logic          empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	fcr_pkg::job_t    mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign job_out = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= job_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CNT_W'(1);
		end
	end

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("frame queue pushed while full");

endmodule

// ===== rtl/fcr_back.sv =====
`timescale 1ns / 1ps
module fcr_back (
	input  logic          clk,
	input  logic          arst_n,
	input  fcr_pkg::cfg_t cfg,
	input  logic          q_empty,
	input  fcr_pkg::job_t q_job,
	output logic          q_pop,
	fcr_out_if.source     rsp
);

	localparam int W = fcr_pkg::BYTE_W;

	fcr_pkg::gen_state_t state_q, state_d;
	logic [W-1:0]        reg_q, dlen_q, cnt_q, cnt_d, rsum_q, rsum_d, seed_q, seed_d;
	logic [W-1:0]        data_b;

	logic                out_valid_q, last_q;
	fcr_pkg::kind_t      kind_q, nkind;
	fcr_pkg::verd_t      verd_q, nverd;
	logic [W-1:0]        byte_q, nbyte;
	logic                nlast, produce, adv;

	assign adv    = !out_valid_q || rsp.ready;
	assign data_b = seed_q + cnt_q;

	always_comb begin
		state_d = state_q;
		produce = 1'b0;
		q_pop   = 1'b0;
		nkind   = fcr_pkg::KIND_BYTE;
		nverd   = fcr_pkg::VERD_REPLY;
		nbyte   = '0;
		nlast   = 1'b0;
		rsum_d  = rsum_q;
		cnt_d   = cnt_q;
		seed_d  = seed_q;
		if (adv) begin
			unique case (state_q)
				fcr_pkg::GS_IDLE: begin
					if (!q_empty) begin
						q_pop   = 1'b1;
						produce = 1'b1;
						nkind   = fcr_pkg::KIND_VERDICT;
						nverd   = q_job.verd;
						if (q_job.verd == fcr_pkg::VERD_REPLY)
							state_d = fcr_pkg::GS_REG;
						else
							nlast = 1'b1;
					end
				end
				fcr_pkg::GS_REG: begin
					produce = 1'b1;
					nbyte   = reg_q;
					rsum_d  = reg_q;
					state_d = fcr_pkg::GS_LEN;
				end
				fcr_pkg::GS_LEN: begin
					produce = 1'b1;
					nbyte   = dlen_q;
					rsum_d  = rsum_q + dlen_q;
					cnt_d   = '0;
					state_d = fcr_pkg::GS_DATA;
				end
				fcr_pkg::GS_DATA: begin
					produce = 1'b1;
					nbyte   = data_b;
					rsum_d  = rsum_q + data_b;
					cnt_d   = cnt_q + W'(1);
					if (cnt_q == dlen_q - W'(1))
						state_d = fcr_pkg::GS_SUM;
				end
				fcr_pkg::GS_SUM: begin
					produce = 1'b1;
					nbyte   = rsum_q;
					state_d = fcr_pkg::GS_TAIL;
				end
				fcr_pkg::GS_TAIL: begin
					produce = 1'b1;
					nbyte   = cfg.tail_byte;
					nlast   = 1'b1;
					seed_d  = seed_q + W'(1);
					state_d = fcr_pkg::GS_IDLE;
				end
				default: state_d = fcr_pkg::GS_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fcr_pkg::GS_IDLE;
			seed_q      <= fcr_pkg::SEED_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			seed_q  <= seed_d;
			if (adv)
				out_valid_q <= produce;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			reg_q  <= q_job.reg_b;
			dlen_q <= q_job.dlen;
		end
		rsum_q <= rsum_d;
		cnt_q  <= cnt_d;
		if (adv && produce) begin
			kind_q <= nkind;
			verd_q <= nverd;
			byte_q <= nbyte;
			last_q <= nlast;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.item_kind   = kind_q;
	assign rsp.verdict     = verd_q;
	assign rsp.reply_byte  = byte_q;
	assign rsp.last_of_run = last_q;

	a_verdict_closes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q == fcr_pkg::KIND_VERDICT && verd_q != fcr_pkg::VERD_REPLY
		|-> last_q) else $error("verdict without reply must close the run");
	a_reply_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q == fcr_pkg::KIND_BYTE |-> verd_q == fcr_pkg::VERD_REPLY)
		else $error("reply byte carries wrong verdict");
	a_data_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fcr_pkg::GS_DATA |-> dlen_q != '0 && cnt_q < dlen_q)
		else $error("data counter ran past reply length");

endmodule

// ===== rtl/frame_check_and_readback_reply.sv =====
`timescale 1ns / 1ps
// Frame checker with read-back reply.
// req: one word per received byte (has_byte, rx_byte, frame_end); a word with
// has_byte low and frame_end low is ignored. A word with frame_end high closes
// the frame and yields one verdict word on rsp, followed by the reply bytes
// (register, length, data, sum, tail) when the verdict is "reply follows";
// last_of_run marks the final rsp word of each closed frame.
// Throughput: req takes one word per clock while the frame queue (4 entries)
// has room; rsp gives one word per clock while rsp is ready and words are
// pending, so a reply of length N gives N + 5 rsp words. With the reply sequencer
// idle, the verdict reaches rsp through the queue and the output register.
// The checker and the reply sequencer are decoupled by the queue: a stalled
// rsp holds its word in the output register, and req keeps taking words
// until the queue fills with closed frames.
// Reset clears the frame state, the queue, the output register and the config
// registers (to zero); the reply data seed returns to 0x10.
// Registers are written over APB at byte address 4*index, data in bits 7:0.
module frame_check_and_readback_reply #(
	parameter int RX_BUFFER_BYTES = fcr_pkg::RX_BUFFER_BYTES_DEF,
	parameter int TX_BUFFER_BYTES = fcr_pkg::TX_BUFFER_BYTES_DEF,
	parameter int CHECK_RX_SUM    = fcr_pkg::CHECK_RX_SUM_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	fcr_in_if.sink                         req,
	fcr_out_if.source                      rsp,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [fcr_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [fcr_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [fcr_pkg::CFG_DATA_W-1:0] prdata,
	output logic                           pready
);

	localparam int W = fcr_pkg::BYTE_W;

	fcr_pkg::cfg_t    cfg_q;
	fcr_pkg::reg_idx_t idx;
	logic [W-1:0]     rd_b;
	logic             wr_en;

	fcr_pkg::job_t    push_job, pop_job;
	logic             push, pop, q_full, q_empty;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = fcr_pkg::reg_idx_t'(paddr[fcr_pkg::CFG_ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				fcr_pkg::REG_HEADER:    cfg_q.header_byte     <= pwdata[W-1:0];
				fcr_pkg::REG_TAIL:      cfg_q.tail_byte       <= pwdata[W-1:0];
				fcr_pkg::REG_SHORT_CMD: cfg_q.short_read_cmd  <= pwdata[W-1:0];
				fcr_pkg::REG_LONG_CMD:  cfg_q.long_read_cmd   <= pwdata[W-1:0];
				fcr_pkg::REG_SHORT_REG: cfg_q.short_reply_reg <= pwdata[W-1:0];
				fcr_pkg::REG_LONG_REG:  cfg_q.long_reply_reg  <= pwdata[W-1:0];
				fcr_pkg::REG_SHORT_LEN: cfg_q.short_reply_len <= pwdata[W-1:0];
				fcr_pkg::REG_LONG_LEN:  cfg_q.long_reply_len  <= pwdata[W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			fcr_pkg::REG_HEADER:    rd_b = cfg_q.header_byte;
			fcr_pkg::REG_TAIL:      rd_b = cfg_q.tail_byte;
			fcr_pkg::REG_SHORT_CMD: rd_b = cfg_q.short_read_cmd;
			fcr_pkg::REG_LONG_CMD:  rd_b = cfg_q.long_read_cmd;
			fcr_pkg::REG_SHORT_REG: rd_b = cfg_q.short_reply_reg;
			fcr_pkg::REG_LONG_REG:  rd_b = cfg_q.long_reply_reg;
			fcr_pkg::REG_SHORT_LEN: rd_b = cfg_q.short_reply_len;
			fcr_pkg::REG_LONG_LEN:  rd_b = cfg_q.long_reply_len;
			default:                rd_b = '0;
		endcase
		prdata = {{(fcr_pkg::CFG_DATA_W - W){1'b0}}, rd_b};
	end

	fcr_front #(
		.RX_BUFFER_BYTES(RX_BUFFER_BYTES),
		.TX_BUFFER_BYTES(TX_BUFFER_BYTES),
		.CHECK_RX_SUM   (CHECK_RX_SUM)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cfg    (cfg_q),
		.q_full (q_full),
		.q_push (push),
		.q_job  (push_job)
	);

	fcr_queue #(
		.DEPTH(fcr_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.job_in (push_job),
		.pop    (pop),
		.job_out(pop_job),
		.full   (q_full),
		.empty  (q_empty)
	);

	fcr_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.q_empty(q_empty),
		.q_job  (pop_job),
		.q_pop  (pop),
		.rsp    (rsp)
	);

endmodule
